@@ sv/line_tracking_error_unit_assert.svh @@
// ----------------------------------------------------------------------------
// line_tracking_error_unit_assert
// assertion macros shared by the line tracking error unit
// ----------------------------------------------------------------------------
`ifndef LINE_TRACKING_ERROR_UNIT_ASSERT_SVH
`define LINE_TRACKING_ERROR_UNIT_ASSERT_SVH

// same-cycle implication
`define LTE_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("line tracking error unit check failed");

// next-cycle implication
`define LTE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("line tracking error unit check failed");

`endif

@@ sv/lte_pkg.sv @@
// ----------------------------------------------------------------------------
// lte_pkg
// types, register indexes and arithmetic helpers of the line tracking error unit
// ----------------------------------------------------------------------------
package lte_pkg;

	localparam logic [1:0] REG_START_X = 2'd0;
	localparam logic [1:0] REG_START_Y = 2'd1;
	localparam logic [1:0] REG_GOAL_X  = 2'd2;
	localparam logic [1:0] REG_GOAL_Y  = 2'd3;

	localparam int DIV_STEPS = 32;

	// one divider lane
	typedef struct packed {
		logic        neg;
		logic        ovf;
		logic [33:0] rem;
		logic [31:0] low;
		logic [31:0] quo;
	} lte_div_t;

	typedef struct packed {
		logic [31:0] val;
		logic        sat;
	} lte_res_t;

	// one restoring step: bring in the next dividend bit
	function automatic lte_div_t div_step(input lte_div_t d, input logic [33:0] len);
		logic [34:0] tmp;
		logic [34:0] dif;
		logic        ge;
		lte_div_t    r;
		tmp = {d.rem, d.low[31]};
		dif = tmp - {1'b0, len};
		ge  = (tmp >= {1'b0, len});
		r     = d;
		r.rem = ge ? dif[33:0] : tmp[33:0];
		r.low = {d.low[30:0], 1'b0};
		r.quo = {d.quo[30:0], ge};
		return r;
	endfunction

	// apply sign and clip to 32-bit signed
	function automatic lte_res_t sat_out(input logic neg, input logic ovf,
		input logic [32:0] q);
		lte_res_t r;
		logic [31:0] nq;
		nq = 32'd0 - q[31:0];
		if (!neg) begin
			r.sat = ovf || (q > 33'h07FFFFFFF);
			r.val = r.sat ? 32'h7FFFFFFF : q[31:0];
		end else begin
			r.sat = ovf || (q > 33'h080000000);
			r.val = r.sat ? 32'h80000000 : nq;
		end
		return r;
	endfunction

endpackage

@@ sv/line_tracking_error_unit.sv @@
// ----------------------------------------------------------------------------
// line_tracking_error_unit
// cross-track and along-track distance of a position to a configured segment
// ----------------------------------------------------------------------------
// Usage: write start_x/start_y/goal_x/goal_y through cfg_we/cfg_addr/cfg_wdata
// while the block is idle. Each write restarts the segment length unit: two
// squarings, one add, 33 root steps and a rounding step, during all of which
// s_tready is low.
// Input beat: robot position on s_tdata. Output beat: the two distances on
// m_tdata, flags on m_tuser. One output beat per input beat, in order.
// Pipeline: 39 register stages from input accept to m_tvalid: the input
// register, the 32 stages of the restoring divider (one quotient bit per
// stage) and 6 others.
// Throughput: one beat per cycle once the length is known and while m_tready is high.
// Each stage holds only while its successor is full and stalled, so a stalled
// receiver first fills the bubbles in the pipe; input is refused only when
// the whole pipe is full or the length unit is busy. Nothing is lost or repeated.
// Reset clears the segment to all zeros (degenerate, length 0) and empties
// the pipe.
// ----------------------------------------------------------------------------
module line_tracking_error_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // robot_x, robot_y
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // cross_track, along_track
	output logic [1:0]  m_tuser,   // segment_degenerate, result_saturated
	input  logic        cfg_we,
	input  logic [1:0]  cfg_addr,
	input  logic [31:0] cfg_wdata
);
	import lte_pkg::*;

	localparam int NSTG = 39;
	localparam int OUT_STG = NSTG - 1;
	localparam int RND_STG = NSTG - 2;
	localparam int DIV_STG = 4;

	typedef enum logic [2:0] {SQ_IDLE, SQ_MX, SQ_MY, SQ_ADD, SQ_ITER, SQ_FIN} sq_state_t;

	logic signed [31:0] start_x_q, start_y_q, goal_x_q, goal_y_q;
	logic [33:0]        len_q;
	sq_state_t          sq_state_q;
	logic [65:0]        sum_q, prod_q, sh_q;
	logic [35:0]        rem_q;
	logic [33:0]        root_q;
	logic [5:0]         cnt_q;

	logic signed [32:0] dx, dy;
	logic [32:0]        dxm, dym;
	logic [37:0]        sq_tmp, sq_trial, sq_dif;
	logic               sq_ge;

	logic [NSTG-1:0] vld_s;
	logic [NSTG-1:0] adv;
	logic            acc;

	logic signed [32:0] ax_s1, ay_s1;
	logic signed [65:0] pxa_s2, pya_s2, pdxay_s2, pdyax_s2;
	logic signed [66:0] crs_s3, aln_s3;
	logic [66:0]        cmag_s4, amag_s4;
	logic               cneg_s4, aneg_s4;
	lte_div_t           cdiv_sd [0:DIV_STEPS];
	lte_div_t           adiv_sd [0:DIV_STEPS];
	logic [32:0]        cq_s38, aq_s38;
	logic               cneg_s38, aneg_s38, covf_s38, aovf_s38;

	lte_res_t cres, ares;
	logic     deg;

	assign dx  = 33'(goal_x_q) - 33'(start_x_q);
	assign dy  = 33'(goal_y_q) - 33'(start_y_q);
	assign dxm = dx[32] ? 33'd0 - dx : dx;
	assign dym = dy[32] ? 33'd0 - dy : dy;

	// segment length: squaring, then one root bit per cycle
	assign sq_tmp   = {rem_q, sh_q[65:64]};
	assign sq_trial = {2'b00, root_q, 2'b01};
	assign sq_dif   = sq_tmp - sq_trial;
	assign sq_ge    = (sq_tmp >= sq_trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			goal_x_q   <= '0;
			goal_y_q   <= '0;
			len_q      <= '0;
			sum_q      <= '0;
			prod_q     <= '0;
			sh_q       <= '0;
			rem_q      <= '0;
			root_q     <= '0;
			cnt_q      <= '0;
			sq_state_q <= SQ_IDLE;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_START_X: start_x_q <= cfg_wdata;
				REG_START_Y: start_y_q <= cfg_wdata;
				REG_GOAL_X:  goal_x_q  <= cfg_wdata;
				REG_GOAL_Y:  goal_y_q  <= cfg_wdata;
				default: ;
			endcase
			sq_state_q <= SQ_MX;
		end else begin
			unique case (sq_state_q)
				SQ_IDLE: ;
				SQ_MX: begin
					sum_q      <= 66'(dxm) * 66'(dxm);
					sq_state_q <= SQ_MY;
				end
				SQ_MY: begin
					prod_q     <= 66'(dym) * 66'(dym);
					sq_state_q <= SQ_ADD;
				end
				SQ_ADD: begin
					sh_q       <= sum_q + prod_q;
					rem_q      <= '0;
					root_q     <= '0;
					cnt_q      <= 6'd32;
					sq_state_q <= SQ_ITER;
				end
				SQ_ITER: begin
					sh_q   <= {sh_q[63:0], 2'b00};
					rem_q  <= sq_ge ? sq_dif[35:0] : sq_tmp[35:0];
					root_q <= {root_q[32:0], sq_ge};
					cnt_q  <= cnt_q - 6'd1;
					if (cnt_q == 6'd0) begin
						sq_state_q <= SQ_FIN;
					end
				end
				SQ_FIN: begin
					len_q      <= (rem_q > 36'(root_q)) ? root_q + 34'd1 : root_q;
					sq_state_q <= SQ_IDLE;
				end
				default: sq_state_q <= SQ_IDLE;
			endcase
		end
	end

	// stage flow control
	always_comb begin
		adv[OUT_STG] = !vld_s[OUT_STG] || m_tready;
	end

	for (genvar i = 0; i < OUT_STG; i++) begin : g_adv
		assign adv[i] = !vld_s[i] || adv[i+1];
	end

	assign s_tready = adv[0] && (sq_state_q == SQ_IDLE);
	assign acc      = s_tvalid && s_tready;
	assign m_tvalid = vld_s[OUT_STG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (adv[0]) begin
				vld_s[0] <= acc;
			end
			for (int i = 1; i < NSTG; i++) begin
				if (adv[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	// offsets, products, sums, magnitudes, divider load
	always_ff @(posedge clk) begin
		if (adv[0]) begin
			ax_s1 <= 33'($signed(s_tdata[31:0])) - 33'(start_x_q);
			ay_s1 <= 33'($signed(s_tdata[63:32])) - 33'(start_y_q);
		end
		if (adv[1]) begin
			pxa_s2   <= 66'(dx) * 66'(ax_s1);
			pya_s2   <= 66'(dy) * 66'(ay_s1);
			pdxay_s2 <= 66'(dx) * 66'(ay_s1);
			pdyax_s2 <= 66'(dy) * 66'(ax_s1);
		end
		if (adv[2]) begin
			crs_s3 <= 67'(pdxay_s2) - 67'(pdyax_s2);
			aln_s3 <= 67'(pxa_s2) + 67'(pya_s2);
		end
		if (adv[3]) begin
			cneg_s4 <= crs_s3[66];
			aneg_s4 <= aln_s3[66];
			cmag_s4 <= crs_s3[66] ? 67'd0 - crs_s3 : crs_s3;
			amag_s4 <= aln_s3[66] ? 67'd0 - aln_s3 : aln_s3;
		end
		if (adv[DIV_STG]) begin
			cdiv_sd[0].neg <= cneg_s4;
			cdiv_sd[0].ovf <= (cmag_s4[66:32] >= {1'b0, len_q});
			cdiv_sd[0].rem <= cmag_s4[65:32];
			cdiv_sd[0].low <= cmag_s4[31:0];
			cdiv_sd[0].quo <= '0;
			adiv_sd[0].neg <= aneg_s4;
			adiv_sd[0].ovf <= (amag_s4[66:32] >= {1'b0, len_q});
			adiv_sd[0].rem <= amag_s4[65:32];
			adiv_sd[0].low <= amag_s4[31:0];
			adiv_sd[0].quo <= '0;
		end
	end

	// restoring divider, one quotient bit per stage
	for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_div
		always_ff @(posedge clk) begin
			if (adv[DIV_STG + k]) begin
				cdiv_sd[k] <= div_step(cdiv_sd[k-1], len_q);
				adiv_sd[k] <= div_step(adiv_sd[k-1], len_q);
			end
		end
	end

	// round half away from zero, then clip
	always_ff @(posedge clk) begin
		if (adv[RND_STG]) begin
			cq_s38   <= {1'b0, cdiv_sd[DIV_STEPS].quo} +
				33'({cdiv_sd[DIV_STEPS].rem, 1'b0} >= {1'b0, len_q});
			aq_s38   <= {1'b0, adiv_sd[DIV_STEPS].quo} +
				33'({adiv_sd[DIV_STEPS].rem, 1'b0} >= {1'b0, len_q});
			cneg_s38 <= cdiv_sd[DIV_STEPS].neg;
			aneg_s38 <= adiv_sd[DIV_STEPS].neg;
			covf_s38 <= cdiv_sd[DIV_STEPS].ovf;
			aovf_s38 <= adiv_sd[DIV_STEPS].ovf;
		end
	end

	assign cres = sat_out(cneg_s38, covf_s38, cq_s38);
	assign ares = sat_out(aneg_s38, aovf_s38, aq_s38);
	assign deg  = (len_q == 34'd0);

	always_ff @(posedge clk) begin
		if (adv[OUT_STG]) begin
			m_tdata <= deg ? 64'd0 : {ares.val, cres.val};
			m_tuser <= {!deg && (cres.sat || ares.sat), deg};
		end
	end

	`include "line_tracking_error_unit_assert.svh"

	`LTE_ASSERT_NOW(a_degenerate_zero, m_tvalid && m_tuser[0], (m_tdata == 64'd0) && !m_tuser[1])
	`LTE_ASSERT_NEXT(a_cfg_starts_length, cfg_we, sq_state_q == SQ_MX)

endmodule
